FILE: rtl/spb_pkg.sv
// ----------------------------------------------------------------------------
// spb_pkg: shared constants and codes for the sparse paged bit set
// Defaults for the top-level parameters, field widths and operation codes.
// ----------------------------------------------------------------------------
package spb_pkg;

    localparam int PAGE_BITS_DEF     = 1024;
    localparam int PAGE_SLOTS_DEF    = 16;
    localparam int POSITION_BITS_DEF = 32;

    localparam int MODE_W    = 2;
    localparam int POS_W     = 32;
    localparam int TOTAL_W   = 15;
    localparam int PAGES_W   = 5;
    localparam int WORD_W    = 64;
    localparam int WORD_SH   = 6;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // Operation codes; the unused code behaves as a test.
    typedef enum logic [MODE_W-1:0] {
        MODE_TEST  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

endpackage

FILE: rtl/sparse_paged_bitset_core.sv
// ----------------------------------------------------------------------------
// sparse_paged_bitset_core: sparse bit set over a pool of fixed-size pages
// Tests, sets or clears one bit per beat. Pages are found by tag, allocated
// and zeroed on the first set in their range, and freed when empty.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents (low bit first)
//  --------+-----+------------------------------------------------------------
//  s_      | in  | mode[1:0], position[33:2], zero fill to 40 bits
//  m_      | out | previous_bit, changed, out_of_pages, total_count[17:3],
//          |     | pages_in_use[22:18], zero fill to 24 bits
//
//  Steps per beat, accept to accept: accept, a scan of the tag slots, word
//  read, update, result load. A hit ends the scan at its slot, a miss that
//  allocates nothing skips read and update, and a set that allocates a page
//  zeroes the page's words in place of the read. The tag scan dominates: one
//  shared comparator walks the tag RAM one slot per cycle.
//  Reset: synchronous, active low; slot valid flags and counts clear at once,
//  no RAM clearing pass. Stalls: a held result waits in the output register;
//  the next beat is accepted meanwhile and its result holds in DONE.
//
module sparse_paged_bitset_core #(
    parameter int PAGE_BITS     = spb_pkg::PAGE_BITS_DEF,
    parameter int PAGE_SLOTS    = spb_pkg::PAGE_SLOTS_DEF,
    parameter int POSITION_BITS = spb_pkg::POSITION_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode[1:0], position[33:2], zero [39:34]
    input  logic [spb_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // previous_bit[0], changed[1], out_of_pages[2], total_count[17:3],
    // pages_in_use[22:18], zero [23]
    output logic [spb_pkg::M_TDATA_W-1:0]  m_tdata
);

    import spb_pkg::*;

    // Geometry derived from the parameters (PAGE_BITS is a power of two).
    localparam int PosW      = (POSITION_BITS < POS_W) ? POSITION_BITS : POS_W;
    localparam int OffW      = $clog2(PAGE_BITS);
    localparam int TagW      = (PosW > OffW) ? PosW - OffW : 1;
    localparam int CntW      = OffW + 1;
    localparam int MetaW     = TagW + CntW;
    localparam int Words     = PAGE_BITS / WORD_W;
    localparam int WordSh    = OffW - WORD_SH;
    localparam int ZW        = (Words > 1) ? $clog2(Words) : 1;
    localparam int SlotW     = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
    localparam int WordDepth = PAGE_SLOTS * Words;
    localparam int AW        = (WordDepth > 1) ? $clog2(WordDepth) : 1;
    localparam int TotW      = $clog2(PAGE_SLOTS * PAGE_BITS + 1);
    localparam int PgW       = $clog2(PAGE_SLOTS + 1);

    localparam logic [POS_W-1:0] PosMask =
        (PosW >= POS_W) ? {POS_W{1'b1}} : POS_W'((64'(1) << PosW) - 64'(1));
    localparam logic [SlotW-1:0] LastSlot = SlotW'(PAGE_SLOTS - 1);
    localparam logic [ZW-1:0]    LastWord = ZW'(Words - 1);
    localparam logic [PgW-1:0]   FullPages = PgW'(PAGE_SLOTS);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_ZERO = 6'b000100,
        ST_RD   = 6'b001000,
        ST_MOD  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [TagW-1:0]       tag_reg, tag_next;
    logic [OffW-1:0]       off_reg, off_next;
    logic [SlotW-1:0]      scan_idx_reg, scan_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [SlotW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  free_found_reg, free_found_next;
    logic [SlotW-1:0]      free_idx_reg, free_idx_next;
    logic [SlotW-1:0]      slot_reg, slot_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic                  fresh_reg, fresh_next;
    logic [ZW-1:0]         zcnt_reg, zcnt_next;
    logic [PAGE_SLOTS-1:0] valid_reg, valid_next;
    logic [PgW-1:0]        pages_reg, pages_next;
    logic [TotW-1:0]       total_reg, total_next;
    logic                  prev_reg, prev_next;
    logic                  chg_reg, chg_next;
    logic                  oop_reg, oop_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    // Tag RAM: {page bit count, page tag} per slot.
    logic                  meta_we;
    logic [MetaW-1:0]      meta_wdata;
    logic [MetaW-1:0]      meta_rdata;
    logic [TagW-1:0]       meta_tag;
    logic [CntW-1:0]       meta_cnt;

    // Word RAM: 64-bit data words, page-major.
    logic                  word_we;
    logic [AW-1:0]         word_addr;
    logic [AW-1:0]         zero_addr;
    logic [AW-1:0]         word_waddr;
    logic [WORD_W-1:0]     word_wdata;
    logic [WORD_W-1:0]     word_rdata;

    logic [POS_W-1:0]      pos_eff;
    logic                  hit;
    logic                  free_now;
    logic [SlotW-1:0]      free_pick;
    logic [WORD_W-1:0]     bit_mask;
    logic [WORD_W-1:0]     cur_word;
    logic                  cur_bit;
    logic [CntW-1:0]       cnt_dec;

    spb_ram #(
        .DATA_W (MetaW),
        .DEPTH  (PAGE_SLOTS),
        .ADDR_W (SlotW)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (slot_reg),
        .wdata (meta_wdata),
        .raddr (scan_idx_reg),
        .rdata (meta_rdata)
    );

    spb_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (WordDepth),
        .ADDR_W (AW)
    ) u_word_ram (
        .aclk  (aclk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (word_wdata),
        .raddr (word_addr),
        .rdata (word_rdata)
    );

    assign pos_eff    = s_tdata[MODE_W +: POS_W] & PosMask;
    assign meta_tag   = meta_rdata[TagW-1:0];
    assign meta_cnt   = meta_rdata[MetaW-1:TagW];
    assign word_addr  = (AW'(slot_reg) << WordSh) | AW'(off_reg >> WORD_SH);
    assign zero_addr  = (AW'(slot_reg) << WordSh) | AW'(zcnt_reg);
    assign word_waddr = (state_reg == ST_ZERO) ? zero_addr : word_addr;

    // Shared tag comparator: one slot per cycle, compared in the cycle after its read.
    assign hit       = cmp_vld_reg && valid_reg[cmp_idx_reg] && (meta_tag == tag_reg);
    assign free_now  = free_found_reg || !valid_reg[cmp_idx_reg];
    assign free_pick = free_found_reg ? free_idx_reg : cmp_idx_reg;

    // Bit update path on the word just read (or a freshly zeroed word).
    assign bit_mask = WORD_W'(1) << off_reg[WORD_SH-1:0];
    assign cur_word = fresh_reg ? '0 : word_rdata;
    assign cur_bit  = |(cur_word & bit_mask);
    assign cnt_dec  = (cnt_reg != '0) ? cnt_reg - CntW'(1) : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        tag_next        = tag_reg;
        off_next        = off_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        fresh_next      = fresh_reg;
        zcnt_next       = zcnt_reg;
        valid_next      = valid_reg;
        pages_next      = pages_reg;
        total_next      = total_reg;
        prev_next       = prev_reg;
        chg_next        = chg_reg;
        oop_next        = oop_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        meta_we         = 1'b0;
        meta_wdata      = {cnt_reg, tag_reg};
        word_we         = 1'b0;
        word_wdata      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // Latch the request and start the slot walk.
                    mode_next       = s_tdata[MODE_W-1:0];
                    tag_next        = TagW'(pos_eff >> OffW);
                    off_next        = pos_eff[OffW-1:0];
                    scan_idx_next   = '0;
                    free_found_next = 1'b0;
                    prev_next       = 1'b0;
                    chg_next        = 1'b0;
                    oop_next        = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue the next tag read, compare the one issued last cycle.
                cmp_vld_next = 1'b1;
                cmp_idx_next = scan_idx_reg;
                if (scan_idx_reg != LastSlot) begin
                    scan_idx_next = scan_idx_reg + SlotW'(1);
                end
                if (cmp_vld_reg) begin
                    if (!free_found_reg && !valid_reg[cmp_idx_reg]) begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                    if (hit) begin
                        slot_next    = cmp_idx_reg;
                        cnt_next     = meta_cnt;
                        fresh_next   = 1'b0;
                        cmp_vld_next = 1'b0;
                        state_next   = ST_RD;
                    end else if (cmp_idx_reg == LastSlot) begin
                        cmp_vld_next = 1'b0;
                        if (mode_reg == MODE_SET) begin
                            if (free_now) begin
                                // Take the lowest free slot and zero it.
                                slot_next              = free_pick;
                                valid_next[free_pick]  = 1'b1;
                                pages_next             = pages_reg + PgW'(1);
                                cnt_next               = '0;
                                zcnt_next              = '0;
                                state_next             = ST_ZERO;
                            end else begin
                                oop_next   = 1'b1;
                                state_next = ST_DONE;
                            end
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_ZERO: begin
                word_we    = 1'b1;
                word_wdata = '0;
                zcnt_next  = zcnt_reg + ZW'(1);
                if (zcnt_reg == LastWord) begin
                    fresh_next = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_RD: begin
                // Word read is in flight; data lands for the update.
                state_next = ST_MOD;
            end
            ST_MOD: begin
                prev_next  = cur_bit;
                state_next = ST_DONE;
                case (mode_reg)
                    MODE_SET: begin
                        if (!cur_bit) begin
                            word_we    = 1'b1;
                            word_wdata = cur_word | bit_mask;
                            chg_next   = 1'b1;
                            cnt_next   = cnt_reg + CntW'(1);
                            total_next = total_reg + TotW'(1);
                            meta_we    = 1'b1;
                            meta_wdata = {cnt_reg + CntW'(1), tag_reg};
                        end
                    end
                    MODE_CLEAR: begin
                        if (cur_bit) begin
                            word_we    = 1'b1;
                            word_wdata = cur_word & ~bit_mask;
                            chg_next   = 1'b1;
                            cnt_next   = cnt_dec;
                            if (total_reg != '0) begin
                                total_next = total_reg - TotW'(1);
                            end
                            meta_we    = 1'b1;
                            meta_wdata = {cnt_dec, tag_reg};
                            if (cnt_dec == '0) begin
                                // Page emptied: free its slot.
                                valid_next[slot_reg] = 1'b0;
                                pages_next           = pages_reg - PgW'(1);
                            end
                        end
                    end
                    default: begin
                        // Test (and the unused code): read only.
                    end
                endcase
            end
            ST_DONE: begin
                // Hold until the output register is free or being drained.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, PAGES_W'(pages_reg), TOTAL_W'(total_reg),
                                    oop_reg, chg_reg, prev_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            slot_reg       <= '0;
            zcnt_reg       <= '0;
            fresh_reg      <= 1'b0;
            valid_reg      <= '0;
            pages_reg      <= '0;
            total_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            slot_reg       <= slot_next;
            zcnt_reg       <= zcnt_next;
            fresh_reg      <= fresh_next;
            valid_reg      <= valid_next;
            pages_reg      <= pages_next;
            total_reg      <= total_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        tag_reg    <= tag_next;
        off_reg    <= off_next;
        cnt_reg    <= cnt_next;
        prev_reg   <= prev_next;
        chg_reg    <= chg_next;
        oop_reg    <= oop_next;
        m_data_reg <= m_data_next;
    end

    // Page counter tracks the slot valid flags.
    a_pages_match: assert property (@(posedge aclk) disable iff (!aresetn)
        pages_reg == PgW'($countones(valid_reg)))
        else $error("pages_in_use out of step with slot valid flags");

    // Pool exhaustion is only reported with every slot taken.
    a_oop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && oop_reg) |-> (pages_reg == FullPages))
        else $error("out_of_pages raised with a free slot");

    // Zeroing runs only on a slot that was just claimed.
    a_zero_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ZERO) |-> valid_reg[slot_reg])
        else $error("zeroing a slot that is not allocated");

    // A newly set bit always advances the total by one.
    a_total_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOD && mode_reg == MODE_SET && !cur_bit)
        |=> (total_reg == $past(total_reg) + TotW'(1)))
        else $error("set did not advance the total count");

endmodule

FILE: rtl/spb_ram.sv
// ----------------------------------------------------------------------------
// spb_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spb_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
